// ===== design/wrs_pkg.sv =====
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types and constants of the weighted roulette selector: operation and
// status codes, controller states, the packed table entry and RAM requests.
// ----------------------------------------------------------------------------
package wrs_pkg;

  localparam int unsigned IDX_W   = 8;
  localparam int unsigned W_W     = 24;
  localparam int unsigned DEG_W   = 9;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned UNI_W   = 16;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd2;

  localparam logic [DEG_W-1:0] DEG_MAX = 9'd511;

  typedef enum logic [2:0] {
    OP_LOAD       = 3'd0,
    OP_ADJUST     = 3'd1,
    OP_PICK       = 3'd2,
    OP_RESTORE    = 3'd3,
    OP_INC_DEGREE = 3'd4
  } wrs_op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_NO_HIT = 2'd2
  } wrs_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MODIFY,
    S_PICK,
    S_RESTORE,
    S_OUT
  } wrs_state_e;

  typedef struct packed {
    logic                    mark;
    logic [DEG_W-1:0]        degree;
    logic signed [W_W-1:0]   weight;
  } wrs_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    wrs_entry_t       wr_data;
  } wrs_entry_req_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
  } wrs_list_req_t;

endpackage

// ===== design/wrs_entry_ram.sv =====
// ----------------------------------------------------------------------------
// wrs_entry_ram
// Entry table RAM holding weight, degree and restore mark, one read and one
// write port, registered read. A valid bit per entry makes unwritten entries
// read as zero right after reset.
// ----------------------------------------------------------------------------
module wrs_entry_ram #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wrs_pkg::wrs_entry_req_t req_i,
  output wrs_pkg::wrs_entry_t     rd_data_o
);
  import wrs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  wrs_entry_t       mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  wrs_entry_t       rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== design/wrs_list_ram.sv =====
// ----------------------------------------------------------------------------
// wrs_list_ram
// Pending restore list: entry numbers in the order they were first adjusted.
// One read and one write port, registered read, no reset.
// ----------------------------------------------------------------------------
module wrs_list_ram #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk_i,
  input  wrs_pkg::wrs_list_req_t        req_i,
  output logic [wrs_pkg::IDX_W-1:0]     rd_data_o
);
  import wrs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data[AW-1:0];
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = IDX_W'(rd_q);

endmodule

// ===== design/weighted_roulette_selector.sv =====
// ----------------------------------------------------------------------------
// weighted_roulette_selector
// Weighted table with a running positive total, roulette pick, lazy restore.
// ----------------------------------------------------------------------------
// Load, adjust and increment degree read the entry and write it back in S_MODIFY; the
// result is registered from S_OUT. Pick walks at most min(entry_count, table depth) entries,
// reading one entry per cycle. Restore passes every pending entry through a four-stage
// read-modify-write pipeline over both RAMs.
// One item at a time; a waiting result holds back only the next result, not the next
// transfer. Reset is immediate: per-entry valid bits make the table read as zero.
module weighted_roulette_selector #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wrs_pkg::W_W-1:0]           cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        op_i,
  input  logic [wrs_pkg::IDX_W-1:0]         index_i,
  input  logic signed [wrs_pkg::W_W-1:0]    amount_i,
  input  logic [wrs_pkg::UNI_W-1:0]         uniform_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wrs_pkg::IDX_W-1:0]         picked_index_o,
  output logic [1:0]                        status_o,
  output logic [wrs_pkg::TOT_W-1:0]         total_weight_o
);
  import wrs_pkg::*;

  // Only the first 256 entries can ever be addressed.
  localparam int unsigned DEPTH = (ENTRIES < 256) ? ENTRIES : 256;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  function automatic logic is_pos(logic signed [W_W-1:0] w);
    return !w[W_W-1] && (w != '0);
  endfunction

  function automatic logic signed [W_W-1:0] sat24(logic signed [34:0] x);
    if (x > 35'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (x < -35'sd8388608) begin
      return 24'sh800000;
    end
    return x[W_W-1:0];
  endfunction

  // Total minus the old positive part plus the new one, clamped to 32 bits.
  function automatic logic [TOT_W-1:0] upd_total(logic [TOT_W-1:0] tot,
                                                 logic signed [W_W-1:0] ow,
                                                 logic signed [W_W-1:0] nw);
    logic signed [33:0] t;
    t = signed'({2'b00, tot});
    if (is_pos(ow)) t = t - 34'(ow);
    if (is_pos(nw)) t = t + 34'(nw);
    if (t < 0) begin
      return '0;
    end else if (t > 34'sh0FFFFFFFF) begin
      return '1;
    end
    return t[TOT_W-1:0];
  endfunction

  wrs_state_e state_q, state_d;

  logic signed [W_W-1:0] base_q, clust_q;
  logic [CNT_W-1:0]      ecount_q;

  logic [TOT_W-1:0]      total_q, total_d;
  logic [CW-1:0]         pcnt_q, pcnt_d;

  logic [2:0]            op_q, op_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic signed [W_W-1:0] amt_q, amt_d;

  logic [TOT_W-1:0]      v_q, v_d;
  logic [CW-1:0]         walk_q, walk_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [AW-1:0]         chk_idx_q, chk_idx_d;

  logic [CW-1:0]         k_q, k_d;
  logic                  s1_vld_q, s1_vld_d;
  logic                  s2_vld_q, s2_vld_d;
  logic [AW-1:0]         s2_addr_q, s2_addr_d;
  logic                  s3_vld_q, s3_vld_d;
  logic [AW-1:0]         s3_addr_q, s3_addr_d;
  logic signed [33:0]    s3_prod_q, s3_prod_d;
  wrs_entry_t            s3_old_q, s3_old_d;

  logic [IDX_W-1:0]      res_picked_q, res_picked_d;
  wrs_status_e           res_status_q, res_status_d;

  logic                  out_valid_q;
  logic [IDX_W-1:0]      out_picked_q;
  wrs_status_e           out_status_q;
  logic [TOT_W-1:0]      out_total_q;
  logic                  out_load;

  wrs_entry_req_t        ent_req;
  wrs_entry_t            ent_rd;
  wrs_list_req_t         list_req;
  logic [IDX_W-1:0]      list_rd;

  logic                  accept;
  logic                  idx_ok;
  logic [CW-1:0]         n_walk;
  logic [CNT_W-1:0]      n_full;
  logic signed [W_W-1:0] new_w;
  logic                  hit;

  wrs_entry_ram #(.DEPTH(DEPTH)) u_entry_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ent_req),
    .rd_data_o (ent_rd)
  );

  wrs_list_ram #(.DEPTH(DEPTH)) u_list_ram (
    .clk_i     (clk_i),
    .req_i     (list_req),
    .rd_data_o (list_rd)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign idx_ok     = (ENTRIES > 256) || (CNT_W'(index_i) < CNT_W'(DEPTH));
  assign n_full     = (ecount_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : ecount_q;
  assign n_walk     = n_full[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= 24'sd256;
      clust_q  <= '0;
      ecount_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE:    base_q   <= cfg_data_i;
        CFG_CLUSTER: clust_q  <= cfg_data_i;
        CFG_COUNT:   ecount_q <= cfg_data_i[CNT_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      pcnt_q      <= '0;
      chk_vld_q   <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      pcnt_q    <= pcnt_d;
      chk_vld_q <= chk_vld_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      s3_vld_q  <= s3_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    idx_q        <= idx_d;
    amt_q        <= amt_d;
    v_q          <= v_d;
    walk_q       <= walk_d;
    chk_idx_q    <= chk_idx_d;
    k_q          <= k_d;
    s2_addr_q    <= s2_addr_d;
    s3_addr_q    <= s3_addr_d;
    s3_prod_q    <= s3_prod_d;
    s3_old_q     <= s3_old_d;
    res_picked_q <= res_picked_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_picked_q <= res_picked_q;
      out_status_q <= res_status_q;
      out_total_q  <= total_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    pcnt_d       = pcnt_q;
    op_d         = op_q;
    idx_d        = idx_q;
    amt_d        = amt_q;
    v_d          = v_q;
    walk_d       = walk_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    k_d          = k_q;
    s1_vld_d     = s1_vld_q;
    s2_vld_d     = s2_vld_q;
    s2_addr_d    = s2_addr_q;
    s3_vld_d     = s3_vld_q;
    s3_addr_d    = s3_addr_q;
    s3_prod_d    = s3_prod_q;
    s3_old_d     = s3_old_q;
    res_picked_d = res_picked_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    new_w        = '0;
    hit          = 1'b0;
    ent_req      = '0;
    list_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = op_i;
          idx_d        = index_i;
          amt_d        = amount_i;
          res_picked_d = '0;
          res_status_d = STAT_OK;
          unique case (op_i)
            OP_LOAD, OP_ADJUST, OP_INC_DEGREE: begin
              if (idx_ok) begin
                ent_req.rd_en   = 1'b1;
                ent_req.rd_addr = index_i;
                state_d         = S_MODIFY;
              end else begin
                state_d = S_OUT;
              end
            end
            OP_PICK: begin
              if (total_q == '0) begin
                res_status_d = STAT_EMPTY;
                state_d      = S_OUT;
              end else begin
                v_d       = TOT_W'((48'(uniform_i) * 48'(total_q)) >> UNI_W);
                walk_d    = '0;
                chk_vld_d = 1'b0;
                state_d   = S_PICK;
              end
            end
            OP_RESTORE: begin
              k_d      = '0;
              s1_vld_d = 1'b0;
              s2_vld_d = 1'b0;
              s3_vld_d = 1'b0;
              state_d  = S_RESTORE;
            end
            default: state_d = S_OUT;
          endcase
        end
      end

      S_MODIFY: begin
        ent_req.wr_addr = idx_q;
        unique case (op_q)
          OP_LOAD: begin
            ent_req.wr_en   = 1'b1;
            ent_req.wr_data = '{mark: ent_rd.mark, degree: '0, weight: base_q};
            total_d         = upd_total(total_q, ent_rd.weight, base_q);
          end
          OP_ADJUST: begin
            new_w           = sat24(35'(ent_rd.weight) + 35'(amt_q));
            ent_req.wr_en   = 1'b1;
            ent_req.wr_data = '{mark: 1'b1, degree: ent_rd.degree, weight: new_w};
            total_d         = upd_total(total_q, ent_rd.weight, new_w);
            // First adjust since the last restore queues the entry.
            if (!ent_rd.mark && (pcnt_q < CW'(DEPTH))) begin
              list_req.wr_en   = 1'b1;
              list_req.wr_addr = IDX_W'(pcnt_q[AW-1:0]);
              list_req.wr_data = idx_q;
              pcnt_d           = pcnt_q + 1'b1;
            end
          end
          OP_INC_DEGREE: begin
            ent_req.wr_en   = 1'b1;
            ent_req.wr_data = ent_rd;
            if (ent_rd.degree < DEG_MAX) begin
              ent_req.wr_data.degree = ent_rd.degree + 1'b1;
            end
          end
          default: ;
        endcase
        state_d = S_OUT;
      end

      S_PICK: begin
        // ent_rd holds entry chk_idx_q when chk_vld_q is set.
        hit = chk_vld_q && is_pos(ent_rd.weight) &&
              (v_q < TOT_W'(unsigned'(ent_rd.weight)));
        if (hit) begin
          res_picked_d = IDX_W'(chk_idx_q);
          state_d      = S_OUT;
        end else if (!chk_vld_q && (walk_q >= n_walk)) begin
          res_status_d = STAT_NO_HIT;
          state_d      = S_OUT;
        end else begin
          if (chk_vld_q && is_pos(ent_rd.weight)) begin
            v_d = v_q - TOT_W'(unsigned'(ent_rd.weight));
          end
          if (walk_q < n_walk) begin
            ent_req.rd_en   = 1'b1;
            ent_req.rd_addr = IDX_W'(walk_q[AW-1:0]);
            chk_vld_d       = 1'b1;
            chk_idx_d       = walk_q[AW-1:0];
            walk_d          = walk_q + 1'b1;
          end else begin
            chk_vld_d = 1'b0;
          end
        end
      end

      S_RESTORE: begin
        // Listed entries are distinct, so the stages never touch the same entry.
        if (k_q < pcnt_q) begin
          list_req.rd_en   = 1'b1;
          list_req.rd_addr = IDX_W'(k_q[AW-1:0]);
          k_d              = k_q + 1'b1;
          s1_vld_d         = 1'b1;
        end else begin
          s1_vld_d = 1'b0;
        end
        s2_vld_d = s1_vld_q;
        if (s1_vld_q) begin
          ent_req.rd_en   = 1'b1;
          ent_req.rd_addr = list_rd;
          s2_addr_d       = list_rd[AW-1:0];
        end
        s3_vld_d = s2_vld_q;
        if (s2_vld_q) begin
          s3_prod_d = clust_q * signed'({1'b0, ent_rd.degree});
          s3_old_d  = ent_rd;
          s3_addr_d = s2_addr_q;
        end
        if (s3_vld_q) begin
          new_w           = sat24(35'(base_q) + 35'(s3_prod_q));
          ent_req.wr_en   = 1'b1;
          ent_req.wr_addr = IDX_W'(s3_addr_q);
          ent_req.wr_data = '{mark: 1'b0, degree: s3_old_q.degree, weight: new_w};
          total_d         = upd_total(total_q, s3_old_q.weight, new_w);
        end
        if ((k_q >= pcnt_q) && !s1_vld_q && !s2_vld_q && !s3_vld_q) begin
          pcnt_d  = '0;
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign picked_index_o = out_picked_q;
  assign status_o       = out_status_q;
  assign total_weight_o = out_total_q;

endmodule
